// File: design/fir_filter_causal_assert.svh
// ----------------------------------------------------------------------------
// fir_filter_causal assertion macros
// Shared property templates for the checker of the causal fir filter.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CAUSAL_ASSERT_SVH
`define FIR_FILTER_CAUSAL_ASSERT_SVH

// antecedent and consequent in the same cycle
`define FCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fir filter check failed");

// consequent in the cycle after the antecedent
`define FCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fir filter check failed");

`endif

// File: design/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Types and constants shared by the causal fir filter modules.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 40;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int DIGIT_BITS  = 4;
  localparam int NUM_DIGITS  = SAMPLE_BITS / DIGIT_BITS;
  localparam int ADDR_W      = $clog2(MAX_TAPS);
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int DIG_W       = $clog2(NUM_DIGITS);
  localparam int PROD_BITS   = SAMPLE_BITS + DIGIT_BITS + 1;
  localparam int SHIFT_W     = $clog2((NUM_DIGITS - 1) * DIGIT_BITS + 1);
  localparam int TAPCNT_W    = 6;
  localparam int Q_BITS      = ACC_BITS + 1 - FRAC_BITS;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;

  localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(1) << (FRAC_BITS - 1);

  // item kinds
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // register word index
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   hist_we;
    logic                   hist_clr;
    logic [ADDR_W-1:0]      hist_waddr;
    logic [SAMPLE_BITS-1:0] hist_wdata;
    logic [ADDR_W-1:0]      hist_raddr;
    logic                   tap_we;
    logic [ADDR_W-1:0]      tap_waddr;
    logic [SAMPLE_BITS-1:0] tap_wdata;
    logic [ADDR_W-1:0]      tap_raddr;
  } store_ctrl_t;

  typedef struct packed {
    logic             clr;
    logic             load;
    logic             step;
    logic             last;
    logic [DIG_W-1:0] dig;
  } mac_ctrl_t;

endpackage

// File: design/fcf_store.sv
// ----------------------------------------------------------------------------
// fcf_store
// Sample history and coefficient memories with registered reads; per-entry
// valid bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module fcf_store import fcf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  store_ctrl_t                   ctrl,
  output logic signed [SAMPLE_BITS-1:0] hist_rdata,
  output logic signed [SAMPLE_BITS-1:0] tap_rdata
);

  logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];

  logic [MAX_TAPS-1:0]    hist_valid_r, hist_valid_nxt;
  logic [MAX_TAPS-1:0]    tap_valid_r, tap_valid_nxt;
  logic [SAMPLE_BITS-1:0] hist_q_r, tap_q_r;
  logic                   hist_ok_r, tap_ok_r;

  always_comb begin
    hist_valid_nxt = hist_valid_r;
    tap_valid_nxt  = tap_valid_r;
    if (ctrl.hist_we) begin
      if (ctrl.hist_clr) begin
        hist_valid_nxt = '0;
      end
      hist_valid_nxt[ctrl.hist_waddr] = 1'b1;
    end
    if (ctrl.tap_we) begin
      tap_valid_nxt[ctrl.tap_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= '0;
      tap_valid_r  <= '0;
    end else begin
      hist_valid_r <= hist_valid_nxt;
      tap_valid_r  <= tap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.hist_we) begin
      hist_mem[ctrl.hist_waddr] <= ctrl.hist_wdata;
    end
    hist_q_r  <= hist_mem[ctrl.hist_raddr];
    hist_ok_r <= hist_valid_r[ctrl.hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.tap_we) begin
      tap_mem[ctrl.tap_waddr] <= ctrl.tap_wdata;
    end
    tap_q_r  <= tap_mem[ctrl.tap_raddr];
    tap_ok_r <= tap_valid_r[ctrl.tap_raddr];
  end

  assign hist_rdata = hist_ok_r ? $signed(hist_q_r) : '0;
  assign tap_rdata  = tap_ok_r ? $signed(tap_q_r) : '0;

endmodule

// File: design/fcf_mac.sv
// ----------------------------------------------------------------------------
// fcf_mac
// Digit-serial multiply-accumulate: while stepping, the sample shifts out one
// 4-bit digit a cycle, each digit times coefficient adds to the 40-bit sum.
// ----------------------------------------------------------------------------
module fcf_mac import fcf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] hist_data,
  input  logic signed [SAMPLE_BITS-1:0] tap_data,
  output logic signed [ACC_BITS-1:0]    acc
);

  logic [SAMPLE_BITS-1:0]        x_sh_r, x_sh_nxt;
  logic signed [SAMPLE_BITS-1:0] tap_r, tap_nxt;
  logic signed [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic signed [DIGIT_BITS:0]    digit;
  logic signed [PROD_BITS-1:0]   partial;
  logic [ACC_BITS-1:0]           part_ext;
  logic [SHIFT_W-1:0]            shamt;

  always_comb begin
    // top digit carries the sample sign
    digit    = $signed({ctrl.last ? x_sh_r[DIGIT_BITS-1] : 1'b0, x_sh_r[DIGIT_BITS-1:0]});
    partial  = tap_r * digit;
    part_ext = {{(ACC_BITS - PROD_BITS){partial[PROD_BITS-1]}}, partial};
    shamt    = SHIFT_W'(ctrl.dig) * SHIFT_W'(DIGIT_BITS);

    x_sh_nxt = x_sh_r;
    tap_nxt  = tap_r;
    acc_nxt  = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end
    if (ctrl.load) begin
      x_sh_nxt = hist_data;
      tap_nxt  = tap_data;
    end else if (ctrl.step) begin
      x_sh_nxt = x_sh_r >> DIGIT_BITS;
      acc_nxt  = acc_r + $signed(part_ext << shamt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_sh_r <= x_sh_nxt;
    tap_r  <= tap_nxt;
  end

  assign acc = acc_r;

endmodule

// File: design/fir_filter_causal.sv
// ----------------------------------------------------------------------------
// fir_filter_causal
// Flow: a sample item steps through read, then a load and four digit
//   multiplies for each tap in use (at most 32; straight to done when
//   none), then done; a load item leaves the input open. The single
//   digit-serial mac holds off new items until the last result is registered.
// Reset: control clears, tap_count returns to 1, history and coefficients
//   read as zero through valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module fir_filter_causal import fcf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic                          in_first,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [ADDR_W-1:0]             in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0] in_tap_value,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_filtered,
  output logic                          out_clipped,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [DIG_W-1:0]       dig_r, dig_nxt;
  logic [ADDR_W-1:0]      cur_wp_r, cur_wp_nxt;
  logic [ADDR_W-1:0]      wp_r, wp_nxt;
  logic [TAPCNT_W-1:0]    tap_count_r, tap_count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_filtered_r, out_filtered_nxt;
  logic                   out_clipped_r, out_clipped_nxt;

  logic                          in_acc, smp_acc, last_dig, last_tap, out_free;
  logic [CNT_W-1:0]              k_inc, rd_k, n_clamp;
  logic [ADDR_W-1:0]             wr_pos;
  logic                          reg_we;
  store_ctrl_t                   st_ctrl;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] hist_rdata, tap_rdata;
  logic signed [ACC_BITS-1:0]    acc;
  logic [ACC_BITS:0]             rnd_sum;
  logic [Q_BITS-1:0]             q;
  logic                          q_fits;

  assign in_acc   = in_valid && in_ready;
  assign smp_acc  = in_acc && (in_action == ACT_FILTER);
  assign k_inc    = k_r + CNT_W'(1);
  assign last_dig = (dig_r == DIG_W'(NUM_DIGITS - 1));
  assign last_tap = (k_inc == n_r);
  assign out_free = !out_valid_r || out_ready;
  assign wr_pos   = in_first ? '0 : wp_r;
  assign n_clamp  = (tap_count_r > TAPCNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                        : CNT_W'(tap_count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (smp_acc) begin
          state_nxt = (n_clamp == '0) ? S_DONE : S_READ;
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MUL;
      S_MUL: begin
        if (last_dig) begin
          state_nxt = last_tap ? S_DONE : S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    // during the multiply the next coefficient is already being fetched
    rd_k     = (state_r == S_MUL) ? k_inc : k_r;

    st_ctrl.hist_we    = smp_acc;
    st_ctrl.hist_clr   = in_first;
    st_ctrl.hist_waddr = wr_pos;
    st_ctrl.hist_wdata = in_sample;
    st_ctrl.hist_raddr = cur_wp_r - rd_k[ADDR_W-1:0];
    st_ctrl.tap_we     = in_acc && (in_action == ACT_LOAD);
    st_ctrl.tap_waddr  = in_tap_index;
    st_ctrl.tap_wdata  = in_tap_value;
    st_ctrl.tap_raddr  = rd_k[ADDR_W-1:0];

    mac_ctrl.clr  = smp_acc;
    mac_ctrl.load = (state_r == S_LOAD);
    mac_ctrl.step = (state_r == S_MUL);
    mac_ctrl.last = last_dig;
    mac_ctrl.dig  = dig_r;
  end

  // round half up, shift and saturate
  always_comb begin
    rnd_sum = {acc[ACC_BITS-1], acc} + ROUND_HALF;
    q       = rnd_sum[ACC_BITS:FRAC_BITS];
    q_fits  = (&q[Q_BITS-1:SAMPLE_BITS-1]) || !(|q[Q_BITS-1:SAMPLE_BITS-1]);
  end

  // datapath registers
  always_comb begin
    k_nxt            = k_r;
    n_nxt            = n_r;
    dig_nxt          = dig_r;
    cur_wp_nxt       = cur_wp_r;
    wp_nxt           = wp_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_filtered_nxt = out_filtered_r;
    out_clipped_nxt  = out_clipped_r;
    if (smp_acc) begin
      cur_wp_nxt = wr_pos;
      wp_nxt     = wr_pos + ADDR_W'(1);
      k_nxt      = '0;
      n_nxt      = n_clamp;
    end
    if (state_r == S_LOAD) begin
      dig_nxt = '0;
    end
    if (state_r == S_MUL) begin
      dig_nxt = dig_r + DIG_W'(1);
      if (last_dig) begin
        k_nxt = k_inc;
      end
    end
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt    = 1'b1;
      out_clipped_nxt  = !q_fits;
      if (q_fits) begin
        out_filtered_nxt = q[SAMPLE_BITS-1:0];
      end else begin
        out_filtered_nxt = {q[Q_BITS-1], {(SAMPLE_BITS - 1){!q[Q_BITS-1]}}};
      end
    end
  end

  // register port
  assign reg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    tap_count_nxt = tap_count_r;
    if (reg_we && (paddr[2] == REG_TAP_COUNT)) begin
      tap_count_nxt = pwdata[TAPCNT_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == REG_TAP_COUNT) begin
      prdata = DATA_W'(tap_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      n_r         <= '0;
      dig_r       <= '0;
      cur_wp_r    <= '0;
      wp_r        <= '0;
      tap_count_r <= TAPCNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      dig_r       <= dig_nxt;
      cur_wp_r    <= cur_wp_nxt;
      wp_r        <= wp_nxt;
      tap_count_r <= tap_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_filtered_r <= out_filtered_nxt;
    out_clipped_r  <= out_clipped_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = $signed(out_filtered_r);
  assign out_clipped  = out_clipped_r;

  fcf_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (st_ctrl),
    .hist_rdata (hist_rdata),
    .tap_rdata  (tap_rdata)
  );

  fcf_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mac_ctrl),
    .hist_data (hist_rdata),
    .tap_data  (tap_rdata),
    .acc       (acc)
  );

endmodule

// File: design/fcf_checker.sv
// ----------------------------------------------------------------------------
// fcf_checker
// Port-level checks for the causal fir filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "fir_filter_causal_assert.svh"

module fcf_checker import fcf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_action,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_filtered,
  input logic                   out_clipped
);

  localparam logic [SAMPLE_BITS-1:0] RAIL_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] RAIL_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // no result shows up in the cycle right after an item is taken
  `FCF_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
  // a sample item keeps the input closed while it is filtered
  `FCF_ASSERT_NEXT(a_busy_after_sample, clk, rst_n, in_valid && in_ready && (in_action == ACT_FILTER), !in_ready)
  // a coefficient load leaves the input open
  `FCF_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, in_valid && in_ready && (in_action == ACT_LOAD), in_ready)
  // a clipped item sits at one of the rails
  `FCF_ASSERT_SAME(a_clip_at_rail, clk, rst_n, out_valid && out_clipped,
                   (out_filtered == RAIL_HI) || (out_filtered == RAIL_LO))
  `FCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_filtered) && $stable(out_clipped))

endmodule

bind fir_filter_causal fcf_checker u_fcf_checker (.*);

// File: bench/tb_fir_filter_causal.sv
// ----------------------------------------------------------------------------
// tb_fir_filter_causal
// Self-checking bench for the causal fir filter. A short directed table
// covers the extremes, rounding of halves, saturation both ways, tap counts
// of zero and above 32 and the first flag. Random sequences follow, each
// segment under its own tap count and idle pattern. Every accepted sample is
// run through an in-bench filter model and every output is checked in order.
// ----------------------------------------------------------------------------
module tb_fir_filter_causal import fcf_pkg::*; ();

  localparam int     LIMIT_CYCLES = 1_000_000;
  localparam int     HOLD_CYCLES  = 1500;
  localparam int     LOAD_SETTLE  = 4;
  localparam int     DRAIN_CYCLES = 5 * MAX_TAPS + 40;
  localparam int     SEGMENTS     = 12;
  localparam int     SEG_ITEMS    = 80;
  localparam longint SAT_HI       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO       = -SAT_HI - 1;

  typedef enum logic {ROW_ITEM, ROW_TAPCOUNT} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic                    action;
    logic                    first;
    logic [SAMPLE_BITS-1:0]  sample;
    logic [ADDR_W-1:0]       tap_index;
    logic [SAMPLE_BITS-1:0]  tap_value;
    logic [TAPCNT_W-1:0]     count;
    logic                    typed;
    logic [SAMPLE_BITS-1:0]  filtered;
    logic                    clipped;
  } dir_row_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered;
    logic                   clipped;
  } fir_out_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_action = ACT_FILTER;
  logic                          in_first = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic [ADDR_W-1:0]             in_tap_index = '0;
  logic signed [SAMPLE_BITS-1:0] in_tap_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_filtered;
  logic                          out_clipped;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_W-1:0]            paddr = '0;
  logic [DATA_W-1:0]             pwdata = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;

  // filter model state
  logic signed [SAMPLE_BITS-1:0] history_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef [MAX_TAPS];
  logic [ADDR_W-1:0]             wr_pos;
  logic [TAPCNT_W-1:0]           tap_limit;

  fir_out_t   pending_outputs [$];
  dir_row_t   directed_rows [$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         seq_left = 0;
  int         stall_reqs = 0;
  int         stall_seen = 0;
  int         stall_left = 0;
  int         cycle_count = 0;

  fir_filter_causal dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_first    (in_first),
    .in_sample   (in_sample),
    .in_tap_index(in_tap_index),
    .in_tap_value(in_tap_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_filtered(out_filtered),
    .out_clipped (out_clipped),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** fir_filter_causal: FAILED **");
      $finish;
    end
  end

  // one filter step: push the sample, sum the taps, round and saturate
  function automatic void fir_output(input logic first, input logic [SAMPLE_BITS-1:0] x,
                                     output fir_out_t res);
    logic signed [ACC_BITS-1:0] acc;
    logic [ADDR_W-1:0]          pos;
    longint                     q;
    int                         n;
    if (first) begin
      foreach (history_q[i]) history_q[i] = '0;
      wr_pos = '0;
    end
    history_q[wr_pos] = x;
    n = (tap_limit > MAX_TAPS) ? MAX_TAPS : int'(tap_limit);
    acc = '0;
    for (int k = 0; k < n; k++) begin
      pos = wr_pos - ADDR_W'(k);
      acc = acc + history_q[pos] * coef[k];
    end
    wr_pos = wr_pos + 1'b1;
    // halves round toward plus infinity
    q = (longint'(acc) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.clipped = 1'b0;
    if (q > SAT_HI) begin
      q = SAT_HI;
      res.clipped = 1'b1;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
      res.clipped = 1'b1;
    end
    res.filtered = q[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_q15();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      1, 2: v = SAMPLE_BITS'($urandom_range(1023)) - SAMPLE_BITS'(512);
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // ignored fields carry random values so the block is seen to ignore them
  function automatic dir_row_t sample_row(logic first, logic [SAMPLE_BITS-1:0] x);
    dir_row_t r;
    r = '0;
    r.kind      = ROW_ITEM;
    r.action    = ACT_FILTER;
    r.first     = first;
    r.sample    = x;
    r.tap_index = ADDR_W'($urandom);
    r.tap_value = SAMPLE_BITS'($urandom);
    return r;
  endfunction

  function automatic dir_row_t known_row(logic first, logic [SAMPLE_BITS-1:0] x,
                                         logic [SAMPLE_BITS-1:0] y, logic clip);
    dir_row_t r;
    r = sample_row(first, x);
    r.typed    = 1'b1;
    r.filtered = y;
    r.clipped  = clip;
    return r;
  endfunction

  function automatic dir_row_t load_row(logic [ADDR_W-1:0] idx, logic [SAMPLE_BITS-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind      = ROW_ITEM;
    r.action    = ACT_LOAD;
    r.first     = 1'($urandom);
    r.sample    = SAMPLE_BITS'($urandom);
    r.tap_index = idx;
    r.tap_value = val;
    return r;
  endfunction

  function automatic dir_row_t count_row(logic [TAPCNT_W-1:0] n);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_TAPCOUNT;
    r.count = n;
    return r;
  endfunction

  // mostly whole sequences opened by a first flag, with loads mixed in
  function automatic dir_row_t random_row();
    logic first;
    if ($urandom_range(99) < 12) return load_row(ADDR_W'($urandom), rand_q15());
    first = 1'b0;
    if (seq_left == 0) begin
      seq_left = $urandom_range(1, 60);
      first = 1'b1;
    end else if ($urandom_range(99) < 3) begin
      first = 1'b1;
    end
    seq_left--;
    return sample_row(first, rand_q15());
  endfunction

  task automatic send_item(input dir_row_t r);
    fir_out_t want;
    int       gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= r.action;
    in_first     <= r.first;
    in_sample    <= r.sample;
    in_tap_index <= r.tap_index;
    in_tap_value <= r.tap_value;
    do @(posedge clk); while (!in_ready);
    if (r.action == ACT_LOAD) begin
      coef[r.tap_index] = r.tap_value;
    end else begin
      fir_output(r.first, r.sample, want);
      if (r.typed) want = '{r.filtered, r.clipped};
      pending_outputs.push_back(want);
    end
  endtask

  task automatic set_tap_count(input logic [TAPCNT_W-1:0] n);
    logic [DATA_W-1:0] word;
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
    word = DATA_W'($urandom);
    word[TAPCNT_W-1:0] = n;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_TAP_COUNT, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    tap_limit  = n;
  endtask

  task automatic apply_row(input dir_row_t r);
    if (r.kind == ROW_TAPCOUNT) set_tap_count(r.count);
    else send_item(r);
  endtask

  task automatic note_mismatch(input fir_out_t want, input fir_out_t got, input bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan)
        $display("[%0t] unexpected output: filtered %0d clipped %0b", $realtime,
                 $signed(got.filtered), got.clipped);
      else
        $display("[%0t] output mismatch: expected filtered %0d clipped %0b, got %0d %0b",
                 $realtime, $signed(want.filtered), want.clipped,
                 $signed(got.filtered), got.clipped);
    end
  endtask

  // receiver: random idling, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_left <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    fir_out_t got;
    fir_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_filtered, out_clipped};
      if (pending_outputs.size() == 0) begin
        note_mismatch(got, got, 1'b1);
      end else begin
        want = pending_outputs.pop_front();
        if (got.filtered !== want.filtered || got.clipped !== want.clipped)
          note_mismatch(want, got, 1'b0);
      end
    end
  end

  initial begin
    foreach (history_q[i]) history_q[i] = '0;
    foreach (coef[i]) coef[i] = '0;
    wr_pos    = '0;
    tap_limit = TAPCNT_W'(1);

    // reset state: one tap, all coefficients zero
    directed_rows.push_back(known_row(1'b1, 16'h7FFF, 16'h0000, 1'b0));
    directed_rows.push_back(load_row(5'd0, 16'h7FFF));
    directed_rows.push_back(known_row(1'b0, 16'h7FFF, 16'h7FFE, 1'b0));
    directed_rows.push_back(load_row(5'd0, 16'h8000));
    directed_rows.push_back(known_row(1'b0, 16'h8000, 16'h7FFF, 1'b1));
    directed_rows.push_back(known_row(1'b0, 16'h7FFF, 16'h8001, 1'b0));
    // exact halves round upward
    directed_rows.push_back(load_row(5'd0, 16'h0001));
    directed_rows.push_back(known_row(1'b0, 16'h4000, 16'h0001, 1'b0));
    directed_rows.push_back(known_row(1'b0, 16'hC000, 16'h0000, 1'b0));
    directed_rows.push_back(load_row(5'd31, 16'h8000));
    directed_rows.push_back(load_row(5'd1, 16'h8000));
    directed_rows.push_back(load_row(5'd0, 16'h8000));
    directed_rows.push_back(count_row(6'd2));
    // negative saturation needs two taps
    directed_rows.push_back(known_row(1'b1, 16'h7FFF, 16'h8001, 1'b0));
    directed_rows.push_back(known_row(1'b0, 16'h7FFF, 16'h8000, 1'b1));
    directed_rows.push_back(sample_row(1'b1, 16'h0000));
    directed_rows.push_back(count_row(6'd0));
    directed_rows.push_back(known_row(1'b0, 16'h7FFF, 16'h0000, 1'b0));
    directed_rows.push_back(count_row(6'd63));
    directed_rows.push_back(sample_row(1'b1, 16'h8000));
    directed_rows.push_back(sample_row(1'b0, 16'h7FFF));
    directed_rows.push_back(sample_row(1'b0, 16'h1234));
    directed_rows.push_back(count_row(6'd32));
    directed_rows.push_back(load_row(5'd31, 16'h7FFF));
    directed_rows.push_back(sample_row(1'b0, 16'h7FFF));
    directed_rows.push_back(sample_row(1'b0, 16'h8000));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) apply_row(directed_rows[i]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 6)
        0: set_tap_count(TAPCNT_W'($urandom_range(2, 8)));
        1: set_tap_count(TAPCNT_W'(MAX_TAPS));
        2: set_tap_count(TAPCNT_W'($urandom_range(1, 31)));
        3: set_tap_count(TAPCNT_W'(1));
        4: set_tap_count(TAPCNT_W'($urandom_range(33, 63)));
        default: set_tap_count(TAPCNT_W'(0));
      endcase
      if (seg < 4) begin
        send_idle_pct = 21;
        recv_idle_pct = 63;
      end else if (seg < 8) begin
        send_idle_pct = 63;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold-off while items keep coming
      if (seg == 9) stall_reqs <= stall_reqs + 1;
      repeat (SEG_ITEMS) apply_row(random_row());
    end

    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0)
      $display("** fir_filter_causal: PASSED **");
    else
      $display("** fir_filter_causal: FAILED **");
    $finish;
  end

endmodule
